// ===== design/nfta_pkg.sv =====
// Package: constants, codes and item types shared by the target assign block.
`default_nettype none
package nfta_pkg;
  localparam int MAX_TARGETS = 64;
  localparam int COORD_BITS  = 16;
  localparam int FIELD_BITS  = 16;
  localparam int OUT_IDX_BITS = 6;
  localparam int IDX_BITS  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNT_BITS  = $clog2(MAX_TARGETS + 1);
  localparam int ROOT_BITS = COORD_BITS + 1;
  localparam int RAD_BITS  = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 2;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_ASSIGN = 2'd2;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  taken;
  } tgt_t;

  typedef struct packed {
    logic                  vld;
    logic                  last;
    logic [IDX_BITS-1:0]   idx;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } tag_t;

  typedef struct packed {
    logic shift;
    logic clr_mark;
    logic set_mark;
    logic load;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== design/nfta_cell.sv =====
// One target cell of the rotating target ring.
`default_nettype none
module nfta_cell (
  input  wire logic              clk,
  input  wire nfta_pkg::cell_ctl_t ctl,
  input  wire nfta_pkg::tgt_t    shift_in,
  input  wire logic [nfta_pkg::COORD_BITS-1:0] load_x,
  input  wire logic [nfta_pkg::COORD_BITS-1:0] load_y,
  output nfta_pkg::tgt_t         tgt
);
  import nfta_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.clr_mark) begin
      tgt.taken <= 1'b0;
    end else if (ctl.set_mark) begin
      tgt.taken <= 1'b1;
    end else if (ctl.shift) begin
      tgt <= shift_in;
    end else if (ctl.load) begin
      tgt.x     <= load_x;
      tgt.y     <= load_y;
      tgt.taken <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== design/nfta_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a tag alongside.
`default_nettype none
module nfta_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire nfta_pkg::tag_t              tag_in,
  input  wire logic [nfta_pkg::RAD_BITS-1:0] rad_in,
  output nfta_pkg::tag_t                   tag_out,
  output logic [nfta_pkg::ROOT_BITS-1:0]   root_out
);
  import nfta_pkg::*;

  logic [RAD_BITS-1:0]  rad  [0:ROOT_BITS];
  logic [REM_BITS-1:0]  rem  [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] root [0:ROOT_BITS];
  tag_t                 tag  [0:ROOT_BITS];

  assign rad[0]  = rad_in;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign tag[0]  = tag_in;

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_stage
    logic [REM_BITS-1:0] rem2;
    logic [REM_BITS-1:0] trial;
    assign rem2  = {rem[i][REM_BITS-3:0], rad[i][RAD_BITS-1:RAD_BITS-2]};
    assign trial = {root[i], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) begin
        tag[i+1].vld  <= 1'b0;
        tag[i+1].last <= 1'b0;
      end else begin
        tag[i+1].vld  <= tag[i].vld;
        tag[i+1].last <= tag[i].last;
      end
      tag[i+1].idx <= tag[i].idx;
      tag[i+1].x   <= tag[i].x;
      tag[i+1].y   <= tag[i].y;
      rad[i+1]     <= {rad[i][RAD_BITS-3:0], 2'b00};
      if (rem2 >= trial) begin
        rem[i+1]  <= rem2 - trial;
        root[i+1] <= {root[i][ROOT_BITS-2:0], 1'b1};
      end else begin
        rem[i+1]  <= rem2;
        root[i+1] <= {root[i][ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  assign tag_out  = tag[ROOT_BITS];
  assign root_out = root[ROOT_BITS];
endmodule
`default_nettype wire

// ===== design/nearest_free_target_assign.sv =====
// Top level: target ring, distance pipeline, nearest search and result register.
//
//  channel | signals                                  | direction
//  in      | in_valid in_stall opcode point_x/y selected | item in
//  out     | out_valid out_stall assigned target_x/y target_index | result out
//
// Clear and load complete without leaving IDLE. An assign makes one full ring
// rotation through a single distance unit, then the square root pipeline drains.
// An assign on an empty list skips the scan and gives an unassigned result.
// rst is synchronous and clears count, state and out_valid; marks are not reset.
// in_stall is high while an assign is in progress or its result cannot be stored.
`default_nettype none
module nearest_free_target_assign (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic signed [15:0] point_x,
  input  wire logic signed [15:0] point_y,
  input  wire logic        selected,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             assigned,
  output logic signed [15:0] target_x,
  output logic signed [15:0] target_y,
  output logic [5:0]       target_index
);
  import nfta_pkg::*;

  typedef enum logic [2:0] {IDLE, START, SCAN, DRAIN, FINISH} state_t;

  state_t                state;
  logic [CNT_BITS-1:0]   count;
  logic [IDX_BITS-1:0]   k;
  logic [COORD_BITS-1:0] ax, ay;
  logic                  have;
  logic [ROOT_BITS-1:0]  best_d;
  logic [IDX_BITS-1:0]   best_i;
  logic [COORD_BITS-1:0] best_x, best_y;

  tgt_t      cells [0:MAX_TARGETS-1];
  logic      avail [0:MAX_TARGETS-1];
  logic      all_taken;
  logic      in_acc;
  logic      out_free;
  logic      res_load;
  logic [COORD_BITS-1:0] px, py;

  assign in_stall = (state != IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign res_load = out_free && ((state == START && count == '0) || state == FINISH);
  assign px = point_x[COORD_BITS-1:0];
  assign py = point_y[COORD_BITS-1:0];

  for (genvar p = 0; p < MAX_TARGETS; p++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.shift    = (state == SCAN);
    assign ctl.clr_mark = (in_acc && opcode == OP_CLEAR) || (state == START && all_taken);
    assign ctl.set_mark = (state == FINISH) && out_free && (best_i == IDX_BITS'(p));
    assign ctl.load     = in_acc && opcode == OP_LOAD && count == CNT_BITS'(p);
    assign avail[p]     = !cells[p].taken || (count <= CNT_BITS'(p));
    nfta_cell u_cell (
      .clk(clk), .ctl(ctl), .shift_in(cells[(p + 1) % MAX_TARGETS]),
      .load_x(px), .load_y(py), .tgt(cells[p])
    );
  end

  always_comb begin
    all_taken = 1'b1;
    for (int p = 0; p < MAX_TARGETS; p++) begin
      if (!avail[p]) begin
        all_taken = all_taken;
      end else begin
        all_taken = all_taken && !(count > CNT_BITS'(p));
      end
    end
  end

  // distance front end
  tag_t                  t0, t1, t2, t3, tq;
  logic [COORD_BITS-1:0] dx, dy;
  logic [2*COORD_BITS-1:0] sqx, sqy;
  logic [RAD_BITS-1:0]   rad;
  logic [ROOT_BITS-1:0]  d;
  logic signed [COORD_BITS:0] ddx, ddy;

  always_comb begin
    t0.vld  = (state == SCAN) && (CNT_BITS'(k) < count) && !cells[0].taken;
    t0.last = (state == SCAN) && (k == IDX_BITS'(MAX_TARGETS - 1));
    t0.idx  = k;
    t0.x    = cells[0].x;
    t0.y    = cells[0].y;
    ddx = $signed({cells[0].x[COORD_BITS-1], cells[0].x}) - $signed({ax[COORD_BITS-1], ax});
    ddy = $signed({cells[0].y[COORD_BITS-1], cells[0].y}) - $signed({ay[COORD_BITS-1], ay});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.vld <= 1'b0; t1.last <= 1'b0;
      t2.vld <= 1'b0; t2.last <= 1'b0;
      t3.vld <= 1'b0; t3.last <= 1'b0;
    end else begin
      t1.vld <= t0.vld; t1.last <= t0.last;
      t2.vld <= t1.vld; t2.last <= t1.last;
      t3.vld <= t2.vld; t3.last <= t2.last;
    end
    t1.idx <= t0.idx; t1.x <= t0.x; t1.y <= t0.y;
    t2.idx <= t1.idx; t2.x <= t1.x; t2.y <= t1.y;
    t3.idx <= t2.idx; t3.x <= t2.x; t3.y <= t2.y;
    dx  <= ddx[COORD_BITS] ? COORD_BITS'(-ddx) : ddx[COORD_BITS-1:0];
    dy  <= ddy[COORD_BITS] ? COORD_BITS'(-ddy) : ddy[COORD_BITS-1:0];
    sqx <= dx * dx;
    sqy <= dy * dy;
    rad <= RAD_BITS'(sqx) + RAD_BITS'(sqy);
  end

  nfta_sqrt u_sqrt (
    .clk(clk), .rst(rst), .tag_in(t3), .rad_in(rad), .tag_out(tq), .root_out(d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      have      <= 1'b0;
      k         <= '0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_acc) begin
            if (opcode == OP_CLEAR) begin
              count <= '0;
            end else if (opcode == OP_LOAD) begin
              if (count < CNT_BITS'(MAX_TARGETS)) begin
                count <= count + 1'b1;
              end
            end else if (opcode == OP_ASSIGN && selected) begin
              ax    <= px;
              ay    <= py;
              state <= START;
            end
          end
        end
        START: begin
          have <= 1'b0;
          k    <= '0;
          if (count == '0) begin
            if (out_free) begin
              assigned     <= 1'b0;
              target_x     <= '0;
              target_y     <= '0;
              target_index <= '0;
              state        <= IDLE;
            end
          end else begin
            state <= SCAN;
          end
        end
        SCAN: begin
          k <= k + 1'b1;
          if (k == IDX_BITS'(MAX_TARGETS - 1)) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (tq.last) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            assigned     <= 1'b1;
            target_x     <= FIELD_BITS'(best_x);
            target_y     <= FIELD_BITS'(best_y);
            target_index <= OUT_IDX_BITS'(32'(best_i));
            state        <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (tq.vld && (!have || d < best_d)) begin
        have   <= 1'b1;
        best_d <= d;
        best_i <= tq.idx;
        best_x <= tq.x;
        best_y <= tq.y;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sim/nfta_checker.sv =====
// Checker: watches both channels, predicts nearest free target results and compares.
`timescale 1ns / 100ps
`default_nettype none
module nfta_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [1:0]         opcode,
  input  wire logic signed [15:0] point_x,
  input  wire logic signed [15:0] point_y,
  input  wire logic               selected,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic               assigned,
  input  wire logic signed [15:0] target_x,
  input  wire logic signed [15:0] target_y,
  input  wire logic [5:0]         target_index,
  output int                      fail_count,
  output int                      pending
);
  import nfta_pkg::*;

  typedef struct packed {
    logic              assigned;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [5:0]        index;
  } pick_t;

  logic signed [15:0] store_x [MAX_TARGETS];
  logic signed [15:0] store_y [MAX_TARGETS];
  logic               taken   [MAX_TARGETS];
  int                 count;
  pick_t              picks_due [$];

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      longint unsigned t;
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  task automatic pick_nearest(input logic signed [15:0] ax, input logic signed [15:0] ay);
    pick_t p;
    bit all_taken;
    bit have;
    longint unsigned best_d;
    int best_i;
    p = '0;
    if (count == 0) begin
      picks_due = {picks_due, p};
      return;
    end
    all_taken = 1;
    for (int i = 0; i < count; i++) if (!taken[i]) all_taken = 0;
    if (all_taken) for (int i = 0; i < count; i++) taken[i] = 0;
    have = 0;
    best_d = 0;
    best_i = 0;
    for (int i = 0; i < count; i++) begin
      longint dx, dy;
      longint unsigned d;
      if (taken[i]) continue;
      dx = longint'(store_x[i]) - longint'(ax);
      dy = longint'(store_y[i]) - longint'(ay);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      d = root_floor(dx * dx + dy * dy);
      if (!have || d < best_d) begin
        have = 1;
        best_d = d;
        best_i = i;
      end
    end
    taken[best_i] = 1;
    p.assigned = 1;
    p.x = store_x[best_i];
    p.y = store_y[best_i];
    p.index = best_i[5:0];
    picks_due = {picks_due, p};
  endtask

  always @(posedge clk) begin
    if (rst) begin
      count = 0;
      for (int i = 0; i < MAX_TARGETS; i++) taken[i] = 0;
      picks_due.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (picks_due.size() == 0) begin
          $display("%0t: unexpected result %b %0d %0d %0d", $time, assigned, target_x,
                   target_y, target_index);
          fail_count <= fail_count + 1;
        end else begin
          pick_t e;
          e = picks_due.pop_front();
          if (e.assigned !== assigned || e.x !== target_x || e.y !== target_y ||
              e.index !== target_index) begin
            $display("%0t: mismatch expected %b %0d %0d %0d actual %b %0d %0d %0d", $time,
                     e.assigned, e.x, e.y, e.index, assigned, target_x, target_y,
                     target_index);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (opcode)
          OP_CLEAR: begin
            count = 0;
            for (int i = 0; i < MAX_TARGETS; i++) taken[i] = 0;
          end
          OP_LOAD: if (count < MAX_TARGETS) begin
            store_x[count] = point_x;
            store_y[count] = point_y;
            taken[count] = 0;
            count++;
          end
          OP_ASSIGN: if (selected) pick_nearest(point_x, point_y);
          default: ;
        endcase
      end
    end
    pending <= picks_due.size();
  end
endmodule
`default_nettype wire

// ===== sim/nearest_free_target_assign_tb.sv =====
// Testbench top: drives items into the target assign block and reports the verdict.
`timescale 1ns / 100ps
`default_nettype none
module nearest_free_target_assign_tb;
  import nfta_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         opcode;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic               selected;
  logic               out_valid;
  logic               out_stall;
  logic               assigned;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic [5:0]         target_index;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct;
  int                 stall_pct;
  bit                 hold_off;
  int                 quiet_cycles;

  nearest_free_target_assign DUT (.*);

  nfta_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic sel);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    point_x <= x;
    point_y <= y;
    selected <= sel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'(16'sh7fff - $urandom_range(3));
      1: return 16'(-16'sh8000 + $urandom_range(3));
      2: return 16'($urandom);
      default: return 16'($urandom_range(200) - 100);
    endcase
  endfunction

  task automatic random_phase(input int n);
    for (int k = 0; k < n; k++) begin
      int r;
      r = $urandom_range(99);
      if (r < 3) send_item(OP_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom));
      else if (r < 45) send_item(OP_LOAD, rand_coord(), rand_coord(), 1'($urandom));
      else if (r < 92) send_item(OP_ASSIGN, rand_coord(), rand_coord(), 1);
      else if (r < 97) send_item(OP_ASSIGN, 16'($urandom), 16'($urandom), 0);
      else send_item(OP_UNUSED, 16'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    opcode = OP_CLEAR;
    point_x = 0;
    point_y = 0;
    selected = 0;
    hold_off = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (2) @(negedge clk);
    rst = 0;
    // directed: empty list, extremes, ties, unselected, unknown op, wrap of marks
    send_item(OP_ASSIGN, 0, 0, 1);
    send_item(OP_LOAD, 16'sh7fff, 16'sh7fff, 0);
    send_item(OP_LOAD, -16'sh8000, -16'sh8000, 1);
    send_item(OP_LOAD, 5, 0, 0);
    send_item(OP_LOAD, -5, 0, 0);
    send_item(OP_ASSIGN, 0, 0, 0);
    send_item(OP_UNUSED, 1, 1, 1);
    send_item(OP_ASSIGN, 0, 0, 1);
    send_item(OP_ASSIGN, 0, 0, 1);
    send_item(OP_ASSIGN, -16'sh8000, 16'sh7fff, 1);
    send_item(OP_ASSIGN, 16'sh7fff, -16'sh8000, 1);
    send_item(OP_ASSIGN, 0, 0, 1);
    send_item(OP_CLEAR, 0, 0, 0);
    send_item(OP_ASSIGN, 16'sh7fff, 16'sh7fff, 1);
    for (int i = 0; i < 66; i++) send_item(OP_LOAD, 16'(i * 3 - 99), 16'(-i), 0);
    send_item(OP_ASSIGN, 99, 99, 1);
    settle();
    random_phase(300);
    settle();
    send_idle_pct = 52;
    random_phase(300);
    settle();
    send_idle_pct = 0;
    stall_pct = 52;
    random_phase(300);
    settle();
    send_idle_pct = 9;
    stall_pct = 9;
    random_phase(300);
    settle();
    send_idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (1500) @(negedge clk);
        hold_off = 0;
      end
      random_phase(150);
    join
    settle();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
